// File: src/rsca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsca_pkg
// Shared types and constants of the random slot cell allocator.
// ----------------------------------------------------------------------------
package rsca_pkg;

  // commands
  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_OFFER  = 1'b1;

  // final-result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_PARTIAL  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SLOTS    = 2'd0;
  localparam logic [1:0] CFG_CHANNELS = 2'd1;
  localparam logic [1:0] CFG_SEED     = 2'd2;

  localparam int CFG_DATA_W = 16;

  // reset values
  localparam logic [6:0]  SLOTS_RESET    = 7'd64;
  localparam logic [6:0]  CHANNELS_RESET = 7'd16;
  localparam logic [15:0] SEED_RESET     = 16'd42;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef struct packed {
    logic       command;
    logic [6:0] cell_count;
    logic [5:0] time_offset;
    logic       last_in_list;
  } in_item_t;

  typedef struct packed {
    logic [5:0] cell_time;
    logic [5:0] cell_channel;
    logic       claimed;
    logic [1:0] status;
    logic       last_result;
  } out_item_t;

  // Galois LFSR, shifts right
  function automatic logic [15:0] lfsr_step(input logic [15:0] s);
    logic [15:0] n;
    n = {1'b0, s[15:1]};
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

  // a zero seed would lock the generator
  function automatic logic [15:0] seed_fix(input logic [15:0] s);
    return (s == 16'd0) ? 16'd1 : s;
  endfunction

endpackage
`default_nettype wire

// File: src/rsca_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsca_in_if
// Request channel: valid/ready handshake carrying one request beat.
// ----------------------------------------------------------------------------
interface rsca_in_if import rsca_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/rsca_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsca_out_if
// Result channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface rsca_out_if import rsca_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/random_slot_cell_allocator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// random_slot_cell_allocator_core
// Slotframe cell allocator: random-probe create and single-cell offer,
// one shared bit-serial remainder unit under a small sequencer.
// ----------------------------------------------------------------------------
//  port    dir   handshake        beat
//  in_ch   in    valid/ready      command, cell_count, time_offset, last_in_list
//  out_ch  out   valid/ready      cell_time, cell_channel, claimed, status, last
//  cfg_*   in    cfg_we only      index 0 slots, 1 channels, 2 seed
//
//  Offer: result registered in S_OFFER once the result register is free.
//  Create: each draw is reduced mod the slot count in S_MOD_T (one quotient bit per
//  cycle) and checked in S_CHECK; a claimed slot draws a channel in S_MOD_C and is
//  pushed in S_PUSH, and S_FINISH sends the last result. Ready only when idle.
//  Result register stalls the sequencer when the sink holds ready low.
//  Reset (synchronous, rst_n low): all slots free, LFSR at seed 42.
// ----------------------------------------------------------------------------
module random_slot_cell_allocator_core import rsca_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  rsca_in_if.sink                    in_ch,
  rsca_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OFFER,
    S_DRAW_T,
    S_MOD_T,
    S_CHECK,
    S_MOD_C,
    S_PUSH,
    S_FINISH
  } state_t;

  state_t state_r;

  logic [6:0]       cfg_slots_r;
  logic [6:0]       cfg_chans_r;
  logic [15:0]      lfsr_r;
  logic [SLOTS-1:0] free_map_r;
  logic [SLOTS-1:0] probed_map_r;
  logic [6:0]       claims_r;

  in_item_t         req_r;
  logic [CNT_W-1:0] probed_r;
  logic [6:0]       got_r;
  logic             have_pend_r;
  logic [5:0]       pend_t_r;
  logic [5:0]       pend_ch_r;
  logic [5:0]       cur_t_r;

  // shared remainder unit
  logic [15:0]      div_val_r;
  logic [6:0]       div_d_r;
  logic [5:0]       div_rem_r;
  logic [3:0]       div_cnt_r;
  logic [6:0]       div_trial;
  logic [6:0]       div_sub;
  logic [5:0]       div_rem_nxt;

  logic             out_valid_r;
  out_item_t        out_data_r;
  logic             out_free;
  logic             out_load;

  logic [CNT_W-1:0] slots_eff;
  logic [6:0]       chans_m1;
  logic [15:0]      lfsr_nxt;
  logic [SLOT_W-1:0] probe_idx;
  logic [SLOT_W-1:0] offer_idx;
  logic             offer_ok;
  logic [6:0]       claims_after;
  logic [1:0]       offer_st;

  // effective configuration, clamped to the legal range
  always_comb begin
    if (cfg_slots_r == 7'd0) begin
      slots_eff = CNT_W'(1);
    end else if (cfg_slots_r > 7'(SLOTS)) begin
      slots_eff = CNT_W'(SLOTS);
    end else begin
      slots_eff = cfg_slots_r[CNT_W-1:0];
    end
    if (cfg_chans_r < 7'd2) begin
      chans_m1 = 7'd1;
    end else if (cfg_chans_r > 7'd64) begin
      chans_m1 = 7'd63;
    end else begin
      chans_m1 = cfg_chans_r - 7'd1;
    end
  end

  assign lfsr_nxt = lfsr_step(lfsr_r);

  assign div_trial   = {div_rem_r, div_val_r[15]};
  assign div_sub     = div_trial - div_d_r;
  assign div_rem_nxt = (div_trial >= div_d_r) ? div_sub[5:0] : div_trial[5:0];

  assign probe_idx = div_rem_r[SLOT_W-1:0];
  assign offer_idx = req_r.time_offset[SLOT_W-1:0];

  assign offer_ok = (claims_r < req_r.cell_count)
                 && ({1'b0, req_r.time_offset} < 7'(slots_eff))
                 && free_map_r[offer_idx];
  assign claims_after = claims_r + {6'd0, offer_ok};

  assign offer_st = !req_r.last_in_list               ? ST_OK :
                    (claims_after == 7'd0)            ? ST_NO_SPACE :
                    (claims_after < req_r.cell_count) ? ST_PARTIAL : ST_OK;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_load     = out_free && ((state_r == S_OFFER) || (state_r == S_FINISH)
                                  || ((state_r == S_PUSH) && have_pend_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_slots_r  <= SLOTS_RESET;
      cfg_chans_r  <= CHANNELS_RESET;
      lfsr_r       <= SEED_RESET;
      free_map_r   <= '1;
      probed_map_r <= '0;
      claims_r     <= 7'd0;
      have_pend_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      probed_r     <= '0;
      got_r        <= 7'd0;
      div_cnt_r    <= 4'd0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOTS:    cfg_slots_r <= cfg_data[6:0];
          CFG_CHANNELS: cfg_chans_r <= cfg_data[6:0];
          CFG_SEED:     lfsr_r      <= seed_fix(cfg_data);
          default:      ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r <= in_ch.data;
            if (in_ch.data.command == CMD_CREATE) begin
              probed_map_r <= '0;
              probed_r     <= '0;
              got_r        <= 7'd0;
              have_pend_r  <= 1'b0;
              state_r      <= S_DRAW_T;
            end else begin
              state_r <= S_OFFER;
            end
          end
        end

        S_OFFER: begin
          if (out_free) begin
            if (offer_ok) begin
              free_map_r[offer_idx] <= 1'b0;
            end
            out_data_r.cell_time     <= req_r.time_offset;
            out_data_r.cell_channel  <= 6'd0;
            out_data_r.claimed       <= offer_ok;
            out_data_r.last_result   <= req_r.last_in_list;
            out_data_r.status        <= offer_st;
            if (req_r.last_in_list) begin
              claims_r <= 7'd0;
            end else begin
              claims_r <= claims_after;
            end
            state_r <= S_IDLE;
          end
        end

        S_DRAW_T: begin
          if ((probed_r < slots_eff) && (got_r < req_r.cell_count)) begin
            lfsr_r    <= lfsr_nxt;
            div_val_r <= lfsr_nxt;
            div_d_r   <= 7'(slots_eff);
            div_rem_r <= 6'd0;
            div_cnt_r <= 4'd0;
            state_r   <= S_MOD_T;
          end else begin
            state_r <= S_FINISH;
          end
        end

        S_MOD_T, S_MOD_C: begin
          div_rem_r <= div_rem_nxt;
          div_val_r <= {div_val_r[14:0], 1'b0};
          div_cnt_r <= div_cnt_r + 4'd1;
          if (div_cnt_r == 4'd15) begin
            state_r <= (state_r == S_MOD_T) ? S_CHECK : S_PUSH;
          end
        end

        S_CHECK: begin
          if (probed_map_r[probe_idx]) begin
            // already seen in this create: draw again
            state_r <= S_DRAW_T;
          end else begin
            probed_map_r[probe_idx] <= 1'b1;
            probed_r                <= probed_r + CNT_W'(1);
            if (free_map_r[probe_idx]) begin
              free_map_r[probe_idx] <= 1'b0;
              got_r     <= got_r + 7'd1;
              cur_t_r   <= 6'(probe_idx);
              lfsr_r    <= lfsr_nxt;
              div_val_r <= lfsr_nxt;
              div_d_r   <= chans_m1;
              div_rem_r <= 6'd0;
              div_cnt_r <= 4'd0;
              state_r   <= S_MOD_C;
            end else begin
              state_r <= S_DRAW_T;
            end
          end
        end

        S_PUSH: begin
          // the previous claim goes out only once it is known not to be last
          if (!have_pend_r || out_free) begin
            if (have_pend_r) begin
              out_data_r.cell_time    <= pend_t_r;
              out_data_r.cell_channel <= pend_ch_r;
              out_data_r.claimed      <= 1'b1;
              out_data_r.status       <= ST_OK;
              out_data_r.last_result  <= 1'b0;
            end
            have_pend_r <= 1'b1;
            pend_t_r    <= cur_t_r;
            pend_ch_r   <= div_rem_r + 6'd1;
            state_r     <= S_DRAW_T;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_data_r.last_result <= 1'b1;
            if (have_pend_r) begin
              out_data_r.cell_time    <= pend_t_r;
              out_data_r.cell_channel <= pend_ch_r;
              out_data_r.claimed      <= 1'b1;
              out_data_r.status       <= (got_r < req_r.cell_count) ? ST_PARTIAL : ST_OK;
            end else begin
              out_data_r.cell_time    <= 6'd0;
              out_data_r.cell_channel <= 6'd0;
              out_data_r.claimed      <= 1'b0;
              out_data_r.status       <= ST_NO_SPACE;
            end
            have_pend_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // no claim may be left held back once the sequencer is idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !have_pend_r)
    else $error("pending claim while idle");

  // claims within a create never outrun distinct probes
  a_got_le_probed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_OFFER) |-> ({1'b0, got_r} <= 8'(probed_r)))
    else $error("more claims than probes");

  // slots are never returned to the free map
  a_free_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ((free_map_r & ~$past(free_map_r)) == '0))
    else $error("slot freed");

  // a no-space result carries no claimed cell
  a_nospace_unclaimed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_NO_SPACE)
      |-> (!out_data_r.claimed && out_data_r.last_result))
    else $error("no-space result with claim");

  // the probe map starts clear for every create
  a_create_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.data.command == CMD_CREATE)
      |=> (probed_map_r == '0 && probed_r == '0))
    else $error("probe map not cleared");
`endif

endmodule
`default_nettype wire
